FILE: src/gas_alarm_pkg.sv
// ---------------------------------------------------------------------------
// gas alarm package
// Shared widths, register indexes, modes and curve constants for the gas
// alarm block.
// ---------------------------------------------------------------------------
package gas_alarm_pkg;

  localparam int SamplesPerReadDefault = 5;
  localparam int AdcBitsDefault        = 12;

  localparam int RegIdxW  = 3;
  localparam int RegDataW = 16;

  typedef enum logic [RegIdxW-1:0] {
    REG_RO          = 3'd0,
    REG_TEMP_LIMIT  = 3'd1,
    REG_HUM_LIMIT   = 3'd2,
    REG_CO_LIMIT    = 3'd3,
    REG_SMOKE_LIMIT = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_GAS   = 2'd0,
    MODE_TEMP  = 2'd1,
    MODE_HUM   = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    UPD_NONE  = 2'd0,
    UPD_CO    = 2'd1,
    UPD_SMOKE = 2'd2
  } upd_t;

  localparam logic [22:0] ResMax   = 23'h7FFFFF;
  localparam logic [24:0] SumMax   = 25'h1FFFFFF;
  localparam logic [23:0] RatioMax = 24'hFFFFFF;

  localparam logic signed [31:0] Ln2Q16    = 32'sd45426;
  localparam logic signed [31:0] Log210Q16 = 32'sd217706;
  localparam logic [31:0]        Ln2Q30    = 32'd744261118;
  localparam logic signed [31:0] CurveA    = 32'sd150733;
  localparam logic signed [31:0] CoB       = 32'sd47186;
  localparam logic signed [31:0] CoM       = -32'sd22282;
  localparam logic signed [31:0] SmokeB    = 32'sd34734;
  localparam logic signed [31:0] SmokeM    = -32'sd28836;

endpackage

FILE: src/gas_alarm_div.sv
// ---------------------------------------------------------------------------
// gas alarm divider
// Unsigned restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module gas_alarm_div #(
  parameter int NW = 48,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] nsh;
  logic [DW:0]   rem;
  logic [DW-1:0] dreg;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   trial;
  logic [DW+1:0] diff;

  assign trial = {rem[DW-1:0], nsh[NW-1]};
  assign diff  = {1'b0, trial} - {2'b00, dreg};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      nsh  <= num;
      dreg <= den;
      rem  <= '0;
      quo  <= '0;
      cnt  <= CW'(NW);
    end else if (busy) begin
      nsh <= nsh << 1;
      if (!diff[DW+1]) begin
        rem <= diff[DW:0];
        quo <= {quo[NW-2:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[NW-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule

FILE: src/gas_sensor_ppm_alarm.sv
// ---------------------------------------------------------------------------
// gas sensor ppm alarm
// Gas, temperature and humidity alarm with a fixed-point ppm curve.
// ---------------------------------------------------------------------------
// Usage: items enter on s_axis (tdata = sample, invalid; tuser = mode).
// Every item yields one transfer on m_axis with the latched alert, the
// stored CO and smoke ppm, an update code and the latest temperature and
// humidity. Registers are written through cfg_we/cfg_idx/cfg_data; the user
// must write them only while the block is idle; the block does not enforce it.
// Temperature, humidity and clear items are handled in S_IDLE and go
// straight to S_EMIT. A gas sample spends nearly all of its time in one
// pass of the shared bit-serial divider; a sample at or below zero skips
// the division. The sample that closes a group then runs an average
// division, a ratio division, a leading one search and a log2 squaring
// loop of 16 steps, a quotient division and an exp series of 12 terms
// with one division each.
// One item is processed at a time. The result sits in an output
// register; s_axis_tready rises again as soon as it is loaded, so the
// next item can be taken while the receiver stalls, and its result waits
// until the held one is taken. Reset returns the state machine, the
// configuration registers, the stores and the output flag to their reset values.
// ---------------------------------------------------------------------------
module gas_sensor_ppm_alarm #(
  parameter int SAMPLES_PER_READ = gas_alarm_pkg::SamplesPerReadDefault,
  parameter int ADC_BITS         = gas_alarm_pkg::AdcBitsDefault
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [15:0]                        s_axis_tdata,  // sample[12:0], invalid[13]
  input  logic [1:0]                         s_axis_tuser,  // mode[1:0]
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [55:0]                        m_axis_tdata,
  // alert[0], co_ppm[16:1], smoke_ppm[32:17], temp_now[44:33], humidity_now[54:45]
  output logic [1:0]                         m_axis_tuser,  // gas_update[1:0]
  input  logic                               cfg_we,
  input  logic [gas_alarm_pkg::RegIdxW-1:0]  cfg_idx,
  input  logic [gas_alarm_pkg::RegDataW-1:0] cfg_data
);
  import gas_alarm_pkg::*;

  localparam int CntW = $clog2(2 * SAMPLES_PER_READ + 1);
  localparam logic [31:0] Fs = 32'((1 << ADC_BITS) - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RES, S_AVG, S_RATIO, S_LOG, S_LN, S_QDIV, S_E2,
    S_EXP, S_DONE, S_EMIT
  } state_t;

  state_t state;

  logic [15:0] ro_value, co_limit, smoke_limit;
  logic signed [11:0] temp_limit;
  logic [9:0] hum_limit;

  logic [CntW-1:0] sample_index;
  logic [24:0] resistance_sum;
  logic [15:0] co_store, smoke_store;
  logic signed [11:0] temp_store;
  logic [9:0] humidity_store;
  logic alert_flag;
  upd_t upd;

  logic out_full;
  logic [55:0] out_data;
  logic [1:0] out_user;

  // shared divider
  logic        dv_start, dv_done;
  logic [47:0] dv_num, dv_quo;
  logic [31:0] dv_den;

  gas_alarm_div #(.NW(48), .DW(32)) u_div (
    .clk(clk), .rst(rst), .start(dv_start), .num(dv_num), .den(dv_den),
    .done(dv_done), .quo(dv_quo)
  );

  // working registers
  logic        is_smoke;
  logic [23:0] ratio;
  logic [4:0]  pos;
  logic [31:0] mant;
  logic [15:0] frac;
  logic [4:0]  step;
  logic signed [47:0] acc;
  logic signed [47:0] lnr;
  logic [15:0] efrac;
  logic [3:0]  eint;
  logic [31:0] ey;
  logic [31:0] term, esum;
  logic        pend;

  logic signed [12:0] val;
  logic signed [12:0] in_sample;
  logic [CntW-1:0] idx_inc;
  logic [25:0] sum_try;
  logic [63:0] msq;
  logic [63:0] tprod;
  logic signed [47:0] e10;
  logic signed [79:0] e2prod;
  logic signed [79:0] lnprod;
  logic [15:0] ro_eff;
  logic [47:0] expv;
  logic [15:0] adc_c;

  assign in_sample = s_axis_tdata[12:0];
  assign val = (s_axis_tdata[13] && s_axis_tuser != MODE_CLEAR) ? 13'sd0 : in_sample;
  assign idx_inc = sample_index + 1'b1;
  assign ro_eff = (ro_value == 16'd0) ? 16'd1 : ro_value;
  assign msq = mant * mant;
  assign tprod = term * ey;
  assign lnprod = 80'(acc) * 80'(Ln2Q16);
  assign e10 = acc + 48'(CurveA);
  assign e2prod = 80'(e10) * 80'(Log210Q16);
  assign expv = {16'd0, esum} << eint;
  assign adc_c = ($signed(val) > $signed({1'b0, Fs})) ? Fs[15:0] : 16'(val);
  // a sample at or below zero adds the maximum resistance
  assign sum_try = 26'(resistance_sum) +
                   (pend ? ((dv_quo > 48'(ResMax)) ? 26'(ResMax) : 26'(dv_quo[22:0]))
                         : 26'(ResMax));

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_full;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_user;

  always_ff @(posedge clk) begin
    dv_start <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      ro_value <= 16'd2560; temp_limit <= 12'sd640; hum_limit <= 10'd300;
      co_limit <= 16'd30; smoke_limit <= 16'd1000;
      sample_index <= '0; resistance_sum <= '0;
      co_store <= '0; smoke_store <= '0; temp_store <= '0;
      humidity_store <= '0; alert_flag <= 1'b0;
      out_full <= 1'b0; pend <= 1'b0; upd <= UPD_NONE;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_RO:          ro_value    <= cfg_data;
          REG_TEMP_LIMIT:  temp_limit  <= cfg_data[11:0];
          REG_HUM_LIMIT:   hum_limit   <= cfg_data[9:0];
          REG_CO_LIMIT:    co_limit    <= cfg_data;
          REG_SMOKE_LIMIT: smoke_limit <= cfg_data;
          default: ;
        endcase
      end
      if (out_full && m_axis_tready && state != S_EMIT) out_full <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            upd <= UPD_NONE;
            unique case (mode_t'(s_axis_tuser))
              MODE_GAS: begin
                if (val <= 13'sd0) begin
                  state <= S_RES;
                  pend <= 1'b0;
                end else begin
                  dv_num <= 48'(5 * 256) * 48'(Fs[15:0] - adc_c);
                  dv_den <= 32'(adc_c);
                  dv_start <= 1'b1;
                  pend <= 1'b1;
                  state <= S_RES;
                end
              end
              MODE_TEMP: begin
                temp_store <= (val > 13'sd2047) ? 12'sd2047 :
                              (val < -13'sd2048) ? -12'sd2048 : val[11:0];
                if (((val > 13'sd2047) ? 13'sd2047 :
                     (val < -13'sd2048) ? -13'sd2048 : val) > 13'(temp_limit))
                  alert_flag <= 1'b1;
                state <= S_EMIT;
              end
              MODE_HUM: begin
                humidity_store <= (val < 0) ? 10'd0 :
                                  (val > 13'sd1023) ? 10'd1023 : val[9:0];
                if (((val < 0) ? 10'd0 : (val > 13'sd1023) ? 10'd1023 : val[9:0])
                    < hum_limit)
                  alert_flag <= 1'b1;
                state <= S_EMIT;
              end
              MODE_CLEAR: begin
                alert_flag <= 1'b0;
                state <= S_EMIT;
              end
              default: state <= S_EMIT;
            endcase
          end
        end
        S_RES: begin
          if (!pend || dv_done) begin
            resistance_sum <= sum_try[25] ? SumMax : sum_try[24:0];
            sample_index <= idx_inc;
            if (idx_inc == CntW'(SAMPLES_PER_READ) ||
                idx_inc >= CntW'(2 * SAMPLES_PER_READ)) begin
              is_smoke <= (idx_inc != CntW'(SAMPLES_PER_READ));
              state <= S_AVG;
              pend <= 1'b0;
            end else begin
              state <= S_EMIT;
            end
          end
        end
        S_AVG: begin
          if (!pend) begin
            dv_num <= 48'(resistance_sum);
            dv_den <= 32'(SAMPLES_PER_READ);
            dv_start <= 1'b1;
            pend <= 1'b1;
          end else if (dv_done) begin
            dv_num <= {dv_quo[31:0], 16'd0};
            dv_den <= 32'(ro_eff);
            dv_start <= 1'b1;
            resistance_sum <= '0;
            state <= S_RATIO;
          end
        end
        S_RATIO: begin
          if (dv_done) begin
            ratio <= (dv_quo > 48'(RatioMax)) ? RatioMax : dv_quo[23:0];
            pos <= 5'd23;
            step <= 5'd0;
            frac <= '0;
            pend <= 1'b0;
            state <= S_LOG;
          end
        end
        S_LOG: begin
          // leading one search, then one squaring per cycle
          if (step == 5'd0) begin
            if (ratio == 24'd0) begin
              state <= S_DONE;
              esum <= '1;
              eint <= 4'd15;
            end else if (pos != 5'd0 && !ratio[pos]) begin
              pos <= pos - 1'b1;
            end else begin
              mant <= 32'(ratio) << (5'd30 - pos);
              step <= 5'd16;
            end
          end else begin
            if (msq[61]) begin
              mant <= msq[62:31];
              frac[4'(step - 1'b1)] <= 1'b1;
            end else begin
              mant <= msq[61:30];
            end
            step <= step - 1'b1;
            if (step == 5'd1) state <= S_LN;
          end
        end
        S_LN: begin
          if (!pend) begin
            acc <= (48'(signed'({1'b0, pos})) - 48'sd16) * 48'sd65536 + 48'(frac);
            pend <= 1'b1;
          end else begin
            // floor of product / 2^16 by arithmetic shift
            lnr <= 48'(lnprod >>> 16);
            pend <= 1'b0;
            state <= S_QDIV;
          end
        end
        S_QDIV: begin
          if (!pend) begin
            acc <= (lnr - 48'(is_smoke ? SmokeB : CoB)) * 48'sd65536;
            pend <= 1'b1;
          end else if (!dv_start && !dv_done && step == 5'd0) begin
            // magnitude division, sign fixed later; m is negative
            dv_num <= acc[47] ? -acc : acc;
            dv_den <= 32'(-(is_smoke ? SmokeM : CoM));
            dv_start <= 1'b1;
            step <= 5'd1;
          end else if (dv_done) begin
            acc <= acc[47] ? 48'(dv_quo) : -48'(dv_quo);
            step <= 5'd0;
            pend <= 1'b0;
            state <= S_E2;
          end
        end
        S_E2: begin
          if (!pend) begin
            acc <= 48'(e2prod >>> 16);
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
            if (acc < 0) begin
              esum <= '0; eint <= '0; state <= S_DONE;
            end else if (acc >= 48'sd1048576) begin
              esum <= '1; eint <= 4'd15; state <= S_DONE;
            end else begin
              eint <= acc[19:16];
              efrac <= acc[15:0];
              step <= 5'd0;
              state <= S_EXP;
            end
          end
        end
        S_EXP: begin
          if (step == 5'd0) begin
            ey <= 32'((48'(efrac) * 48'(Ln2Q30)) >> 16);
            term <= 32'h4000_0000;
            esum <= 32'h4000_0000;
            step <= 5'd1;
            pend <= 1'b0;
          end else if (!pend) begin
            dv_num <= 48'(tprod >> 30);
            dv_den <= 32'(step);
            dv_start <= 1'b1;
            pend <= 1'b1;
          end else if (dv_done) begin
            term <= dv_quo[31:0];
            esum <= esum + dv_quo[31:0];
            pend <= 1'b0;
            if (step == 5'd12) begin
              state <= S_DONE;
              step <= 5'd0;
            end else begin
              step <= step + 1'b1;
            end
          end
        end
        S_DONE: begin
          // esum all ones with eint 15 marks saturation
          if (is_smoke) begin
            smoke_store <= (expv[47:30] > 18'd65535) ? 16'hFFFF : expv[45:30];
            upd <= UPD_SMOKE;
            sample_index <= '0;
            if (co_store > co_limit ||
                ((expv[47:30] > 18'd65535) ? 16'hFFFF : expv[45:30]) > smoke_limit)
              alert_flag <= 1'b1;
          end else begin
            co_store <= (expv[47:30] > 18'd65535) ? 16'hFFFF : expv[45:30];
            upd <= UPD_CO;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_full || m_axis_tready) begin
            out_full <= 1'b1;
            out_data <= {1'b0, humidity_store, temp_store, smoke_store, co_store,
                         alert_flag};
            out_user <= upd;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  ap_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !s_axis_tready) else $error("accept while busy");
  ap_emit_fills: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && (!out_full || m_axis_tready)) |=> out_full)
    else $error("result lost");
  ap_upd_code: assert property (@(posedge clk) disable iff (rst)
    out_full |-> (out_user != 2'd3)) else $error("bad update code");
endmodule
